[rtl/core/ibp_pkg.sv]
package ibp_pkg;

   localparam int COORD_W   = 10;
   localparam int CHAN_W    = 2;
   localparam int PIXEL_W   = 8;
   localparam int SIZE_W    = 9;
   localparam int COUNT_W   = 3;
   localparam int PAD_W     = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 9;

   // Padded sizes reach 511 + 2 * 255 and are held with one bit more than a coordinate.
   localparam int SUM_W  = COORD_W + 1;
   // Signed axis arithmetic: offsets from -255 up to 1023, and twice the largest size.
   localparam int AXIS_W = 12;

   localparam logic signed [AXIS_W-1:0] AXIS_ONE = AXIS_W'(1);
   localparam logic signed [AXIS_W-1:0] AXIS_TWO = AXIS_W'(2);

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_X         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_Y         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_MODE      = 3'd5;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef enum logic [1:0] {
      PAD_NONE      = 2'd0,
      PAD_ZERO      = 2'd1,
      PAD_REPLICATE = 2'd2,
      PAD_MIRROR    = 2'd3
   } pad_mode_type;

   typedef struct packed {
      logic              in_range;
      logic              ok;
      logic [AXIS_W-1:0] pos;
   } axis_map_type;

endpackage

[rtl/core/ibp_ram.sv]
module ibp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 262144
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[address] <= write_data;
      end
      read_data_ff <= mem_ff[address];
   end

   assign read_data = read_data_ff;

endmodule

[rtl/core/ibp_axis_map.sv]
module ibp_axis_map (
   input  logic [ibp_pkg::COORD_W-1:0] coord,
   input  logic [ibp_pkg::PAD_W-1:0]   pad,
   input  logic [ibp_pkg::SIZE_W-1:0]  size,
   input  ibp_pkg::pad_mode_type       mode,
   output ibp_pkg::axis_map_type       result
);
   import ibp_pkg::*;

   logic [SUM_W-1:0]         padded_size;
   logic signed [AXIS_W-1:0] offset;
   logic signed [AXIS_W-1:0] size_s;
   logic signed [AXIS_W-1:0] pos;

   assign padded_size = SUM_W'(size) + SUM_W'({pad, 1'b0});
   assign offset      = signed'(AXIS_W'(coord)) - signed'(AXIS_W'(pad));
   assign size_s      = signed'(AXIS_W'(size));

   always_comb begin
      pos = offset;
      case (mode)
         PAD_REPLICATE: begin
            if (offset[AXIS_W-1]) begin
               pos = '0;
            end else if (offset > size_s - AXIS_ONE) begin
               pos = size_s - AXIS_ONE;
            end
         end
         PAD_MIRROR: begin
            if (offset[AXIS_W-1]) begin
               pos = -offset;
            end else if (offset >= size_s) begin
               pos = (size_s <<< 1) - offset - AXIS_TWO;
            end
         end
         default: begin
            pos = offset;
         end
      endcase
   end

   assign result.in_range = SUM_W'(coord) < padded_size;
   assign result.ok       = !pos[AXIS_W-1] && (pos < size_s);
   assign result.pos      = unsigned'(pos);

endmodule

[rtl/core/image_border_padding_unit.sv]
// Frame store with a border-padding read port. One item is accepted in every
// cycle (busy stays low); a write item stores one byte when its column, row and
// channel lie inside the image, and gives no result. A read item passes the
// request register, then its rsp_valid and result leave the result register
// and the registered read of the frame memory together. The frame memory has a
// single port, which makes one access per item. The receiver cannot stall, so
// results are never held back. The frame memory has no reset: a read that maps
// onto an entry never written returns an unspecified byte.
module image_border_padding_unit #(
   parameter int MAX_WIDTH    = 256,
   parameter int MAX_HEIGHT   = 256,
   parameter int MAX_CHANNELS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [ibp_pkg::COORD_W-1:0]   req_col,
   input  logic [ibp_pkg::COORD_W-1:0]   req_row,
   input  logic [ibp_pkg::CHAN_W-1:0]    req_channel,
   input  logic [ibp_pkg::PIXEL_W-1:0]   req_pixel_in,
   output logic                          rsp_valid,
   output logic [ibp_pkg::PIXEL_W-1:0]   rsp_pixel_out,
   output logic                          rsp_range_flag,
   input  logic                          csr_write_enable,
   input  logic [ibp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ibp_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import ibp_pkg::*;

   localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int ADDR_W = XW + YW + CW;
   localparam int DEPTH  = 2 ** ADDR_W;

   localparam logic [SIZE_W-1:0]  W_CAP  =
      (MAX_WIDTH > 511) ? SIZE_W'(511) : SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0]  H_CAP  =
      (MAX_HEIGHT > 511) ? SIZE_W'(511) : SIZE_W'(MAX_HEIGHT);
   localparam logic [COUNT_W-1:0] NC_CAP = COUNT_W'(MAX_CHANNELS);

   logic [SIZE_W-1:0]  image_width_ff,   image_width_in;
   logic [SIZE_W-1:0]  image_height_ff,  image_height_in;
   logic [COUNT_W-1:0] channel_count_ff, channel_count_in;
   logic [PAD_W-1:0]   pad_x_ff,         pad_x_in;
   logic [PAD_W-1:0]   pad_y_ff,         pad_y_in;
   pad_mode_type       pad_mode_ff,      pad_mode_in;

   logic                stg_valid_ff,   stg_valid_in;
   logic                stg_kind_ff,    stg_kind_in;
   logic [COORD_W-1:0]  stg_col_ff,     stg_col_in;
   logic [COORD_W-1:0]  stg_row_ff,     stg_row_in;
   logic [CHAN_W-1:0]   stg_channel_ff, stg_channel_in;
   logic [PIXEL_W-1:0]  stg_pixel_ff,   stg_pixel_in;

   logic                rsp_valid_ff,   rsp_valid_in;
   logic                rsp_hit_ff,     rsp_hit_in;
   logic                rsp_flag_ff,    rsp_flag_in;

   logic [SIZE_W-1:0]   width_eff;
   logic [SIZE_W-1:0]   height_eff;
   logic [COUNT_W-1:0]  count_eff;
   logic                channel_ok;
   logic                write_ok;
   logic                padded_ok;
   logic                mapped_ok;
   logic                is_write;
   axis_map_type        x_map;
   axis_map_type        y_map;

   logic                ram_we;
   logic [XW-1:0]       addr_x;
   logic [YW-1:0]       addr_y;
   logic [CW-1:0]       addr_c;
   logic [ADDR_W-1:0]   ram_addr;
   logic [PIXEL_W-1:0]  ram_rdata;

   // Configuration registers.
   always_comb begin
      image_width_in   = image_width_ff;
      image_height_in  = image_height_ff;
      channel_count_in = channel_count_ff;
      pad_x_in         = pad_x_ff;
      pad_y_in         = pad_y_ff;
      pad_mode_in      = pad_mode_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   image_width_in   = csr_write_data;
            CSR_IMAGE_HEIGHT:  image_height_in  = csr_write_data;
            CSR_CHANNEL_COUNT: channel_count_in = csr_write_data[COUNT_W-1:0];
            CSR_PAD_X:         pad_x_in         = csr_write_data[PAD_W-1:0];
            CSR_PAD_Y:         pad_y_in         = csr_write_data[PAD_W-1:0];
            CSR_PAD_MODE:      pad_mode_in      = pad_mode_type'(csr_write_data[1:0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= SIZE_W'(256);
         image_height_ff  <= SIZE_W'(256);
         channel_count_ff <= COUNT_W'(1);
         pad_x_ff         <= '0;
         pad_y_ff         <= '0;
         pad_mode_ff      <= PAD_ZERO;
      end else begin
         image_width_ff   <= image_width_in;
         image_height_ff  <= image_height_in;
         channel_count_ff <= channel_count_in;
         pad_x_ff         <= pad_x_in;
         pad_y_ff         <= pad_y_in;
         pad_mode_ff      <= pad_mode_in;
      end
   end

   always_comb begin
      if (image_width_ff == '0) begin
         width_eff = SIZE_W'(1);
      end else if (image_width_ff > W_CAP) begin
         width_eff = W_CAP;
      end else begin
         width_eff = image_width_ff;
      end
      if (image_height_ff == '0) begin
         height_eff = SIZE_W'(1);
      end else if (image_height_ff > H_CAP) begin
         height_eff = H_CAP;
      end else begin
         height_eff = image_height_ff;
      end
      if (channel_count_ff == '0) begin
         count_eff = COUNT_W'(1);
      end else if (channel_count_ff > NC_CAP) begin
         count_eff = NC_CAP;
      end else begin
         count_eff = channel_count_ff;
      end
   end

   // Request register.
   assign busy           = 1'b0;
   assign stg_valid_in   = start && !busy;
   assign stg_kind_in    = req_kind;
   assign stg_col_in     = req_col;
   assign stg_row_in     = req_row;
   assign stg_channel_in = req_channel;
   assign stg_pixel_in   = req_pixel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
      stg_kind_ff    <= stg_kind_in;
      stg_col_ff     <= stg_col_in;
      stg_row_ff     <= stg_row_in;
      stg_channel_ff <= stg_channel_in;
      stg_pixel_ff   <= stg_pixel_in;
   end

   // Coordinate mapping and memory access.
   ibp_axis_map u_map_x (
      .coord  (stg_col_ff),
      .pad    (pad_x_ff),
      .size   (width_eff),
      .mode   (pad_mode_ff),
      .result (x_map)
   );

   ibp_axis_map u_map_y (
      .coord  (stg_row_ff),
      .pad    (pad_y_ff),
      .size   (height_eff),
      .mode   (pad_mode_ff),
      .result (y_map)
   );

   assign is_write   = (stg_kind_ff == KIND_WRITE);
   assign channel_ok = COUNT_W'(stg_channel_ff) < count_eff;
   assign write_ok   = (stg_col_ff < COORD_W'(width_eff)) &&
                       (stg_row_ff < COORD_W'(height_eff)) && channel_ok;
   assign padded_ok  = channel_ok && x_map.in_range && y_map.in_range;
   assign mapped_ok  = x_map.ok && y_map.ok;

   assign ram_we   = stg_valid_ff && is_write && write_ok;
   assign addr_x   = is_write ? XW'(stg_col_ff) : XW'(x_map.pos);
   assign addr_y   = is_write ? YW'(stg_row_ff) : YW'(y_map.pos);
   assign addr_c   = CW'(stg_channel_ff);
   assign ram_addr = {addr_y, addr_x, addr_c};

   ibp_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock        (clock),
      .write_enable (ram_we),
      .address      (ram_addr),
      .write_data   (stg_pixel_ff),
      .read_data    (ram_rdata)
   );

   // Result register; the byte itself arrives from the memory's read register.
   assign rsp_valid_in = stg_valid_ff && !is_write;
   assign rsp_hit_in   = padded_ok && (pad_mode_ff != PAD_NONE) && mapped_ok;
   assign rsp_flag_in  = !padded_ok || (pad_mode_ff == PAD_NONE) ||
                         (!mapped_ok && (pad_mode_ff == PAD_MIRROR));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hit_ff  <= rsp_hit_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_hit_ff ? ram_rdata : '0;
   assign rsp_range_flag = rsp_flag_ff;

`ifndef SYNTHESIS
   a_read_gives_result: assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff && stg_kind_ff == KIND_READ) |=> rsp_valid_ff)
      else $error("read item lost its result");

   a_write_gives_none: assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff && stg_kind_ff == KIND_WRITE) |=> !rsp_valid_ff)
      else $error("write item produced a result");

   a_store_write_only_for_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (stg_valid_ff && stg_kind_ff == KIND_WRITE))
      else $error("frame memory written without a write item");

   a_hit_not_flagged: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> !rsp_flag_ff)
      else $error("result both read from memory and flagged");
`endif

endmodule
